>>> rtl/arp_pkg.sv
// Package for the address resolution cache table: field widths, operation
// codes, table entry and result types shared by the RAM user and the top level.
// No dependencies.
package arp_pkg;

    localparam int ENTRIES_DEF = 16;
    localparam int DEVICES     = 4;

    localparam int OP_W    = 3;
    localparam int IP_W    = 32;
    localparam int MAC_W   = 48;
    localparam int DEV_W   = 2;
    localparam int FLAGS_W = 8;
    localparam int SLOT_W  = 4;

    localparam int S_DATA_W = 96;
    localparam int M_DATA_W = 72;

    localparam logic [OP_W-1:0] OP_LOOKUP    = 3'd0;
    localparam logic [OP_W-1:0] OP_ADD       = 3'd1;
    localparam logic [OP_W-1:0] OP_REMOVE    = 3'd2;
    localparam logic [OP_W-1:0] OP_UPDATE    = 3'd3;
    localparam logic [OP_W-1:0] OP_FLUSH     = 3'd4;
    localparam logic [OP_W-1:0] OP_FLUSH_DEV = 3'd5;

    typedef struct packed {
        logic [FLAGS_W-1:0] flags;
        logic [DEV_W-1:0]   dev;
        logic [MAC_W-1:0]   mac;
        logic [IP_W-1:0]    ip;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic [SLOT_W-1:0]  slot;
        logic [FLAGS_W-1:0] found_flags;
        logic [DEV_W-1:0]   found_device;
        logic [MAC_W-1:0]   found_mac;
        logic               request_needed;
        logic               hit;
        logic               success;
    } result_t;

endpackage

>>> rtl/arp_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module arp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/arp_cache_table_top.sv
// Top level of the address resolution cache table: input capture, scan
// sequencer, valid bits and result register. Uses arp_pkg and arp_ram.
//
//  Channel  Direction  Handshake                 Payload
//  s_       in         s_tvalid / s_tready       op, ip_address, mac_address,
//                                                device_id, flags
//  m_       out        m_tvalid / m_tready       success, hit, request_needed,
//                                                found_mac, found_device,
//                                                found_flags, slot
//  cfg_     in         cfg_wr_en (no wait)       permanent_mask
//
// Steps: an operation is captured, then the scan reads up to ENTRIES entries,
// then the result is loaded into the result register once it has drained. The scan
// steps one table entry per cycle through the single read port of the entry
// RAM; lookup, remove and a matched update stop at the first hit, add at the first free slot.
// Unknown op codes, and bad device ids on ops other than lookup and flush, skip the scan.
// Reset clears every valid bit at once; no clearing pass over the RAM.
// The result register holds while m_tready is low; the next transfer on s_ is
// taken as soon as the scan is idle, even with a result still pending.
module arp_cache_table_top
    import arp_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    // config
    input  logic                cfg_wr_en,
    input  logic [FLAGS_W-1:0]  cfg_wr_data,     // permanent_mask
    // input stream
    input  logic                s_tvalid,
    output logic                s_tready,
    // [2:0] op, [34:3] ip_address, [82:35] mac_address,
    // [84:83] device_id, [92:85] flags, [95:93] zero
    input  logic [S_DATA_W-1:0] s_tdata,
    // result stream
    output logic                m_tvalid,
    input  logic                m_tready,
    // [0] success, [1] hit, [2] request_needed, [50:3] found_mac,
    // [52:51] found_device, [60:53] found_flags, [64:61] slot, [71:65] zero
    output logic [M_DATA_W-1:0] m_tdata
);

    localparam int IDX_W = $clog2(ENTRIES);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(ENTRIES - 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    // unpack the input transfer
    logic [OP_W-1:0]    s_op;
    logic [IP_W-1:0]    s_ip;
    logic [MAC_W-1:0]   s_mac;
    logic [DEV_W-1:0]   s_dev;
    logic [FLAGS_W-1:0] s_flags;

    assign s_op    = s_tdata[2:0];
    assign s_ip    = s_tdata[34:3];
    assign s_mac   = s_tdata[82:35];
    assign s_dev   = s_tdata[84:83];
    assign s_flags = s_tdata[92:85];

    logic [1:0]         state_reg, state_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [ENTRIES-1:0] valid_reg, valid_next;
    logic [FLAGS_W-1:0] mask_reg;
    logic               free_found_reg, free_found_next;
    logic [IDX_W-1:0]   free_slot_reg, free_slot_next;
    result_t            res_reg, res_next;
    logic               m_tvalid_reg;
    logic [M_DATA_W-1:0] m_tdata_reg;

    logic [OP_W-1:0]    op_reg, op_next;
    logic [IP_W-1:0]    ip_reg, ip_next;
    logic [MAC_W-1:0]   mac_reg, mac_next;
    logic [DEV_W-1:0]   dev_reg, dev_next;
    logic [FLAGS_W-1:0] flags_reg, flags_next;

    // entry RAM ports
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    entry_t             wr_data;
    logic [ENTRY_W-1:0] rd_data;

    arp_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ENTRIES)
    ) u_entry_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (idx_next),
        .rd_data (rd_data)
    );

    logic   accept;
    logic   dev_ok;
    logic   op_known;
    logic   cur_valid;
    entry_t cur;
    logic   ip_hit;
    logic   last;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign dev_ok   = 32'(s_dev) < 32'(DEVICES);
    assign op_known = (s_op == OP_LOOKUP) || (s_op == OP_ADD) || (s_op == OP_REMOVE) ||
                      (s_op == OP_UPDATE) || (s_op == OP_FLUSH) ||
                      (s_op == OP_FLUSH_DEV);

    // an invalid entry reads as all zero
    assign cur_valid = valid_reg[idx_reg];
    assign cur       = cur_valid ? entry_t'(rd_data) : '0;
    assign ip_hit    = cur_valid && (cur.ip == ip_reg);
    assign last      = (idx_reg == IDX_LAST);

    always_comb begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        valid_next      = valid_reg;
        free_found_next = free_found_reg;
        free_slot_next  = free_slot_reg;
        res_next        = res_reg;
        op_next         = op_reg;
        ip_next         = ip_reg;
        mac_next        = mac_reg;
        dev_next        = dev_reg;
        flags_next      = flags_reg;
        wr_en           = 1'b0;
        wr_addr         = idx_reg;
        wr_data         = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    op_next         = s_op;
                    ip_next         = s_ip;
                    mac_next        = s_mac;
                    dev_next        = s_dev;
                    flags_next      = s_flags;
                    idx_next        = '0;
                    free_found_next = 1'b0;
                    free_slot_next  = '0;
                    res_next        = '0;
                    // lookup and flush ignore the device id
                    if (!op_known) begin
                        state_next = ST_FIN;
                    end else if (!dev_ok && s_op != OP_LOOKUP && s_op != OP_FLUSH) begin
                        state_next = ST_FIN;
                    end else begin
                        state_next = ST_SCAN;
                    end
                end
            end

            ST_SCAN: begin
                state_next = last ? ST_FIN : ST_SCAN;
                idx_next   = last ? idx_reg : IDX_W'(idx_reg + 1'b1);

                unique case (op_reg)
                    OP_LOOKUP: begin
                        if (ip_hit) begin
                            res_next.success      = 1'b1;
                            res_next.hit          = 1'b1;
                            res_next.found_mac    = cur.mac;
                            res_next.found_device = cur.dev;
                            res_next.found_flags  = cur.flags;
                            res_next.slot         = SLOT_W'(idx_reg);
                            state_next            = ST_FIN;
                            idx_next              = idx_reg;
                        end else if (last) begin
                            res_next.request_needed = 1'b1;
                        end
                    end
                    OP_ADD: begin
                        if (!cur_valid) begin
                            wr_en               = 1'b1;
                            wr_data             = '{flags: flags_reg, dev: dev_reg,
                                                    mac: mac_reg, ip: ip_reg};
                            valid_next[idx_reg] = 1'b1;
                            res_next.success    = 1'b1;
                            res_next.slot       = SLOT_W'(idx_reg);
                            state_next          = ST_FIN;
                            idx_next            = idx_reg;
                        end
                    end
                    OP_REMOVE: begin
                        if (ip_hit && cur.dev == dev_reg) begin
                            valid_next[idx_reg] = 1'b0;
                            res_next.success    = 1'b1;
                            res_next.hit        = 1'b1;
                            res_next.slot       = SLOT_W'(idx_reg);
                            state_next          = ST_FIN;
                            idx_next            = idx_reg;
                        end
                    end
                    OP_UPDATE: begin
                        if (ip_hit) begin
                            // keep the stored flags
                            wr_en            = 1'b1;
                            wr_data          = '{flags: cur.flags, dev: dev_reg,
                                                 mac: mac_reg, ip: cur.ip};
                            res_next.success = 1'b1;
                            res_next.hit     = 1'b1;
                            res_next.slot    = SLOT_W'(idx_reg);
                            state_next       = ST_FIN;
                            idx_next         = idx_reg;
                        end else begin
                            if (!cur_valid && !free_found_reg) begin
                                free_found_next = 1'b1;
                                free_slot_next  = idx_reg;
                            end
                            // no match anywhere: insert into the first free slot
                            if (last && free_found_next) begin
                                wr_en                      = 1'b1;
                                wr_addr                    = free_slot_next;
                                wr_data                    = '{flags: '0, dev: dev_reg,
                                                               mac: mac_reg, ip: ip_reg};
                                valid_next[free_slot_next] = 1'b1;
                                res_next.success           = 1'b1;
                                res_next.slot              = SLOT_W'(free_slot_next);
                            end
                        end
                    end
                    OP_FLUSH: begin
                        if ((cur.flags & mask_reg) == '0) begin
                            valid_next[idx_reg] = 1'b0;
                        end
                        if (last) begin
                            res_next.success = 1'b1;
                        end
                    end
                    OP_FLUSH_DEV: begin
                        if (cur_valid && cur.dev == dev_reg) begin
                            valid_next[idx_reg] = 1'b0;
                        end
                        if (last) begin
                            res_next.success = 1'b1;
                        end
                    end
                    default: begin
                        state_next = ST_FIN;
                    end
                endcase
            end

            ST_FIN: begin
                // wait for the result register to drain
                if (!m_tvalid_reg || m_tready) begin
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            valid_reg    <= '0;
            mask_reg     <= FLAGS_W'(1);
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            if (cfg_wr_en) begin
                mask_reg <= cfg_wr_data;
            end
            if (state_reg == ST_FIN && (!m_tvalid_reg || m_tready)) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // payload and scan registers
    always_ff @(posedge aclk) begin
        idx_reg        <= idx_next;
        free_found_reg <= free_found_next;
        free_slot_reg  <= free_slot_next;
        res_reg        <= res_next;
        op_reg         <= op_next;
        ip_reg         <= ip_next;
        mac_reg        <= mac_next;
        dev_reg        <= dev_next;
        flags_reg      <= flags_next;
        if (state_reg == ST_FIN && (!m_tvalid_reg || m_tready)) begin
            m_tdata_reg <= M_DATA_W'(res_reg);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
